[hdl/multilevel_feedback_scheduler_unit_assert.svh]
// Assertion macros for the scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define MFS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication checked in the next clock
`define MFS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/mfs_pkg.sv]
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and constants for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;
    localparam int MAX_PROCS   = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int NUM_CLASSES = 3;
    localparam int AGE_WIDTH   = 8;
    localparam int NQ          = NUM_CLASSES * NUM_LEVELS;
    localparam int PID_W       = $clog2(MAX_PROCS);
    localparam int CNT_W       = $clog2(MAX_PROCS + 1);
    localparam int Q_W         = $clog2(NQ);
    localparam int SLOT_W      = $clog2(NQ * MAX_PROCS);

    typedef enum logic [1:0] {
        FN_ADMIT = 2'd0, FN_REQUEUE = 2'd1, FN_PICK = 2'd2, FN_TICK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2
    } t_status;

    localparam logic [2:0] CFG_Q0 = 3'd0;
    localparam logic [2:0] CFG_Q1 = 3'd1;
    localparam logic [2:0] CFG_Q2 = 3'd2;
    localparam logic [2:0] CFG_T1 = 3'd3;
    localparam logic [2:0] CFG_T2 = 3'd4;

    // queue pointer/count operation request from the sequencer
    typedef struct packed {
        logic           push;
        logic           pop;
        logic [Q_W-1:0] q;
    } t_qop;
endpackage

[hdl/mfs_qctl.sv]
// ----------------------------------------------------------------------------
// mfs_qctl
// Head, tail and count registers of all queues; one push or pop per cycle.
// ----------------------------------------------------------------------------
module mfs_qctl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mfs_pkg::t_qop                i_op,
    input  logic [mfs_pkg::Q_W-1:0]      i_sel,
    output logic [mfs_pkg::PID_W-1:0]    o_head,
    output logic [mfs_pkg::PID_W-1:0]    o_tail,
    output logic [mfs_pkg::CNT_W-1:0]    o_count,
    output logic [mfs_pkg::NQ-1:0]       o_nonempty
);
    import mfs_pkg::*;

    logic [PID_W-1:0] r_head  [NQ];
    logic [PID_W-1:0] r_tail  [NQ];
    logic [CNT_W-1:0] r_count [NQ];

    assign o_head  = r_head[i_sel];
    assign o_tail  = r_tail[i_sel];
    assign o_count = r_count[i_sel];

    always_comb begin
        for (int k = 0; k < NQ; k++) o_nonempty[k] = (r_count[k] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NQ; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else if (i_op.push) begin
            r_tail[i_op.q]  <= r_tail[i_op.q] + 1'b1;
            r_count[i_op.q] <= r_count[i_op.q] + 1'b1;
        end else if (i_op.pop) begin
            r_head[i_op.q]  <= r_head[i_op.q] + 1'b1;
            r_count[i_op.q] <= r_count[i_op.q] - 1'b1;
        end
    end
endmodule

[hdl/multilevel_feedback_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Admit and requeue go through S_PUSH and S_DONE, pick through S_PICK, S_PRD
// and S_DONE. An age tick runs S_TQ per level 1-2 queue and S_TRD, S_TDAT and,
// unless the entry moves up, S_TPUSH per entry there, one queue at a time, set
// by the single slot RAM port and the shared queue-pointer unit. busy is high
// while an item works; the next item can be accepted in the result cycle.
// Synchronous active-low reset clears queue pointers, state and valid, and sets the config registers to default.
// Result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [3:0] i_pid,
    input  logic [1:0] i_proc_class,
    input  logic [1:0] i_req_level,
    input  logic       i_clear_age,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [3:0] o_out_pid,
    output logic [1:0] o_out_level,
    output logic [7:0] o_out_quantum
);
    import mfs_pkg::*;
    `include "multilevel_feedback_scheduler_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_PICK, S_PRD, S_TQ, S_TRD, S_TDAT, S_TPUSH, S_DONE
    } t_state;

    logic [7:0] r_q0, r_q1, r_q2, r_t1, r_t2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0 <= 8'd2; r_q1 <= 8'd4; r_q2 <= 8'd6; r_t1 <= 8'd3; r_t2 <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_Q0:  r_q0 <= i_cfg_data;
                CFG_Q1:  r_q1 <= i_cfg_data;
                CFG_Q2:  r_q2 <= i_cfg_data;
                CFG_T1:  r_t1 <= i_cfg_data;
                CFG_T2:  r_t2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // process tables and slot memory
    logic [1:0]           m_class [MAX_PROCS];
    logic [1:0]           m_level [MAX_PROCS];
    logic [AGE_WIDTH-1:0] m_age   [MAX_PROCS];
    logic [PID_W-1:0]     m_slot  [NQ*MAX_PROCS];

    t_state               r_state;
    logic [1:0]           r_func;
    logic [PID_W-1:0]     r_pid;
    logic [1:0]           r_lvl;
    logic [Q_W-1:0]       r_q;      // target or current queue
    logic [1:0]           r_qc;     // tick class
    logic [1:0]           r_ql;     // tick level
    logic [CNT_W-1:0]     r_n;
    logic [PID_W-1:0]     r_rd;
    logic                 r_full;
    logic                 r_valid;
    logic [1:0]           r_status;
    logic [3:0]           r_opid;
    logic [1:0]           r_olvl;
    logic [7:0]           r_oq;

    t_qop                 qop;
    logic [Q_W-1:0]       qsel;
    logic [PID_W-1:0]     q_head, q_tail;
    logic [CNT_W-1:0]     q_count;
    logic [NQ-1:0]        q_ne;

    mfs_qctl u_qctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(qop), .i_sel(qsel),
        .o_head(q_head), .o_tail(q_tail), .o_count(q_count), .o_nonempty(q_ne)
    );

    // first non-empty queue in class-then-level order
    logic           pk_found;
    logic [Q_W-1:0] pk_q;
    logic [1:0]     pk_l;
    always_comb begin
        pk_found = 1'b0;
        pk_q     = '0;
        pk_l     = '0;
        for (int k = NQ - 1; k >= 0; k--) begin
            if (q_ne[k]) begin
                pk_found = 1'b1;
                pk_q     = Q_W'(k);
                pk_l     = 2'(k % NUM_LEVELS);
            end
        end
    end

    // next level 1-2 queue of the age scan
    logic           scan_last;
    logic [1:0]     nxt_qc, nxt_ql;
    logic [Q_W-1:0] nxt_q;
    always_comb begin
        scan_last = (r_qc == 2'(NUM_CLASSES - 1)) && (r_ql == 2'(NUM_LEVELS - 1));
        if (r_ql == 2'(NUM_LEVELS - 1)) begin
            nxt_qc = r_qc + 1'b1;
            nxt_ql = 2'd1;
            nxt_q  = r_q + Q_W'(2);
        end else begin
            nxt_qc = r_qc;
            nxt_ql = r_ql + 1'b1;
            nxt_q  = r_q + 1'b1;
        end
    end

    // tick arithmetic on the entry just read
    logic [AGE_WIDTH-1:0] age_cur, age_inc;
    logic [7:0]           thr;
    logic                 promote;
    logic [Q_W-1:0]       q_up;
    assign age_cur = m_age[r_rd];
    assign age_inc = (age_cur == '1) ? age_cur : age_cur + 1'b1;
    assign thr     = (r_ql == 2'd1) ? r_t1 : r_t2;
    assign promote = (16'(age_inc) >= 16'(thr));
    assign q_up    = r_q - 1'b1;
    logic up_full;
    logic [CNT_W-1:0] up_count;
    assign up_count = q_count;  // qsel points at q_up in S_TDAT

    always_comb begin
        qop  = '0;
        qsel = r_q;
        unique case (r_state)
            S_PUSH:  qop = '{push: (q_count != CNT_W'(MAX_PROCS)), pop: 1'b0, q: r_q};
            S_PICK:  begin qsel = pk_q; qop = '{push: 1'b0, pop: pk_found, q: pk_q}; end
            S_TRD:   qop = '{push: 1'b0, pop: 1'b1, q: r_q};
            S_TDAT:  begin
                qsel = q_up;
                qop  = '{push: promote && (q_count != CNT_W'(MAX_PROCS)),
                         pop: 1'b0, q: q_up};
            end
            S_TPUSH: qop = '{push: 1'b1, pop: 1'b0, q: r_q};
            default: ;
        endcase
    end
    assign up_full = (up_count == CNT_W'(MAX_PROCS));

    function automatic logic [7:0] quant(input logic [1:0] l, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
        quant = (l == 2'd0) ? a : ((l == 2'd1) ? b : c);
    endfunction

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_PUSH:  if (q_count != CNT_W'(MAX_PROCS))
                         m_slot[{r_q, q_tail}] <= r_pid;
            S_TDAT:  if (promote && !up_full) m_slot[{q_up, q_tail}] <= r_rd;
            S_TPUSH: m_slot[{r_q, q_tail}] <= r_rd;
            default: ;
        endcase
        // head is read before the pop takes effect
        if (r_state == S_TRD) r_rd <= m_slot[{r_q, q_head}];
        else if (r_state == S_PICK) r_rd <= m_slot[{pk_q, q_head}];
        if (start && !busy) begin
            if (t_func'(i_func) == FN_ADMIT) begin
                m_class[i_pid] <= (i_proc_class == 2'd3) ? 2'd2 : i_proc_class;
                m_level[i_pid] <= 2'd0;
                m_age[i_pid]   <= '0;
            end else if (t_func'(i_func) == FN_REQUEUE) begin
                m_level[i_pid] <= (i_req_level > 2'(NUM_LEVELS - 1)) ?
                                  2'(NUM_LEVELS - 1) : i_req_level;
                if (i_clear_age) m_age[i_pid] <= '0;
            end
        end
        if (r_state == S_TDAT) begin
            if (promote && !up_full) begin
                m_level[r_rd] <= r_ql - 1'b1;
                m_age[r_rd]   <= '0;
            end else begin
                m_age[r_rd] <= age_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_func <= i_func;
                    r_pid  <= i_pid;
                    r_full <= 1'b0;
                    r_lvl  <= (i_req_level > 2'(NUM_LEVELS - 1)) ?
                              2'(NUM_LEVELS - 1) : i_req_level;
                    unique case (t_func'(i_func))
                        FN_ADMIT: begin
                            r_q <= Q_W'(((i_proc_class == 2'd3) ? 2'd2 : i_proc_class)
                                        * NUM_LEVELS);
                            r_state <= S_PUSH;
                        end
                        FN_REQUEUE: begin
                            r_q <= Q_W'(m_class[i_pid] * NUM_LEVELS +
                                   ((i_req_level > 2'(NUM_LEVELS - 1)) ?
                                    2'(NUM_LEVELS - 1) : i_req_level));
                            r_state <= S_PUSH;
                        end
                        FN_PICK:  r_state <= S_PICK;
                        FN_TICK: begin
                            r_qc <= 2'd0; r_ql <= 2'd1;
                            r_q <= Q_W'(1); r_state <= S_TQ;
                        end
                    endcase
                end
                S_PUSH: begin
                    r_full  <= (q_count == CNT_W'(MAX_PROCS));
                    r_state <= S_DONE;
                end
                S_PICK: begin
                    r_q <= pk_q;
                    r_lvl <= pk_l;
                    r_full <= !pk_found;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_DONE;
                S_TQ: begin
                    if (q_count != '0) begin
                        r_n     <= q_count;
                        r_state <= S_TRD;
                    end else begin
                        r_qc    <= nxt_qc;
                        r_ql    <= nxt_ql;
                        r_q     <= nxt_q;
                        r_state <= scan_last ? S_DONE : S_TQ;
                    end
                end
                S_TRD: r_state <= S_TDAT;
                S_TDAT: begin
                    if (promote && up_full) r_full <= 1'b1;
                    if (promote && !up_full) begin
                        r_n <= r_n - 1'b1;
                        // last entry of this queue: move on to the next one
                        if (r_n == CNT_W'(1)) begin
                            r_qc    <= nxt_qc;
                            r_ql    <= nxt_ql;
                            r_q     <= nxt_q;
                            r_state <= scan_last ? S_DONE : S_TQ;
                        end else begin
                            r_state <= S_TRD;
                        end
                    end else begin
                        r_state <= S_TPUSH;
                    end
                end
                S_TPUSH: begin
                    r_n <= r_n - 1'b1;
                    if (r_n == CNT_W'(1)) begin
                        r_qc    <= nxt_qc;
                        r_ql    <= nxt_ql;
                        r_q     <= nxt_q;
                        r_state <= scan_last ? S_DONE : S_TQ;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_status <= (r_func == FN_PICK) ? (r_full ? ST_EMPTY : ST_OK)
                                                    : (r_full ? ST_FULL : ST_OK);
                    r_opid <= (r_func == FN_PICK && !r_full) ? 4'(r_rd) : 4'd0;
                    r_olvl <= (r_func == FN_PICK && !r_full) ? r_lvl : 2'd0;
                    r_oq   <= (r_func == FN_PICK && !r_full) ?
                              quant(r_lvl, r_q0, r_q1, r_q2) : 8'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_pid     = r_opid;
    assign o_out_level   = r_olvl;
    assign o_out_quantum = r_oq;

    `MFS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `MFS_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `MFS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY,
                    o_out_quantum == 8'd0)
endmodule

[bench/mfs_checker.sv]
// ----------------------------------------------------------------------------
// mfs_checker
// Watches the command and result channels of the scheduler, keeps its own
// copy of the queues and tables, and compares each result with the expected.
// ----------------------------------------------------------------------------
module mfs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_func,
    input  logic [3:0] i_pid,
    input  logic [1:0] i_proc_class,
    input  logic [1:0] i_req_level,
    input  logic       i_clear_age,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [1:0] i_status,
    input  logic [3:0] i_out_pid,
    input  logic [1:0] i_out_level,
    input  logic [7:0] i_out_quantum,
    output int         o_errors,
    output int         o_pending
);
    import mfs_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] pid;
        logic [1:0] level;
        logic [7:0] quantum;
    } t_sched_result;

    logic [3:0] slot_mem [NQ][MAX_PROCS];
    logic [3:0] head_ptr [NQ];
    logic [3:0] tail_ptr [NQ];
    logic [4:0] fill_cnt [NQ];
    logic [1:0] class_of [MAX_PROCS];
    logic [1:0] level_of [MAX_PROCS];
    logic [7:0] age_of   [MAX_PROCS];
    logic [7:0] quantum_cfg [3];
    logic [7:0] thresh_l1, thresh_l2;

    t_sched_result expected_results [$];

    function automatic bit push_pid(int q, logic [3:0] p);
        if (fill_cnt[q] >= MAX_PROCS) return 0;
        slot_mem[q][tail_ptr[q]] = p;
        tail_ptr[q] = tail_ptr[q] + 1;
        fill_cnt[q] = fill_cnt[q] + 1;
        return 1;
    endfunction

    function automatic logic [3:0] pop_pid(int q);
        logic [3:0] p;
        p = slot_mem[q][head_ptr[q]];
        head_ptr[q] = head_ptr[q] + 1;
        fill_cnt[q] = fill_cnt[q] - 1;
        return p;
    endfunction

    function automatic t_sched_result schedule_step(t_func fn, logic [3:0] pid,
                                                    logic [1:0] cls, logic [1:0] lvl,
                                                    logic clr);
        t_sched_result r;
        bit found;
        bit moved;
        int n;
        logic [3:0] p;
        logic [7:0] th;
        r = '0;
        r.status = ST_OK;
        if (cls > 2) cls = 2;
        if (lvl > NUM_LEVELS - 1) lvl = NUM_LEVELS - 1;
        case (fn)
            FN_ADMIT: begin
                class_of[pid] = cls;
                level_of[pid] = 0;
                age_of[pid] = 0;
                if (!push_pid(cls * NUM_LEVELS, pid)) r.status = ST_FULL;
            end
            FN_REQUEUE: begin
                level_of[pid] = lvl;
                if (clr) age_of[pid] = 0;
                if (!push_pid(class_of[pid] * NUM_LEVELS + lvl, pid)) r.status = ST_FULL;
            end
            FN_PICK: begin
                found = 0;
                for (int c = 0; c < NUM_CLASSES && !found; c++)
                    for (int l = 0; l < NUM_LEVELS && !found; l++)
                        if (fill_cnt[c * NUM_LEVELS + l] != 0) begin
                            r.pid = pop_pid(c * NUM_LEVELS + l);
                            r.level = l;
                            r.quantum = quantum_cfg[l];
                            found = 1;
                        end
                if (!found) r.status = ST_EMPTY;
            end
            default: begin
                for (int c = 0; c < NUM_CLASSES; c++)
                    for (int l = 1; l < NUM_LEVELS; l++) begin
                        n = fill_cnt[c * NUM_LEVELS + l];
                        th = (l == 1) ? thresh_l1 : thresh_l2;
                        for (int i = 0; i < n; i++) begin
                            p = pop_pid(c * NUM_LEVELS + l);
                            moved = 0;
                            if (age_of[p] != 8'hff) age_of[p] = age_of[p] + 1;
                            if (age_of[p] >= th) begin
                                if (push_pid(c * NUM_LEVELS + l - 1, p)) begin
                                    level_of[p] = l - 1;
                                    age_of[p] = 0;
                                    moved = 1;
                                end else begin
                                    r.status = ST_FULL;
                                end
                            end
                            if (!moved) void'(push_pid(c * NUM_LEVELS + l, p));
                        end
                    end
            end
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result exp_r;
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                head_ptr[q] = 0;
                tail_ptr[q] = 0;
                fill_cnt[q] = 0;
            end
            quantum_cfg[0] = 8'd2;
            quantum_cfg[1] = 8'd4;
            quantum_cfg[2] = 8'd6;
            thresh_l1 = 8'd3;
            thresh_l2 = 8'd6;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Q0: quantum_cfg[0] = i_cfg_data;
                    CFG_Q1: quantum_cfg[1] = i_cfg_data;
                    CFG_Q2: quantum_cfg[2] = i_cfg_data;
                    CFG_T1: thresh_l1 = i_cfg_data;
                    CFG_T2: thresh_l2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                got = {i_status, i_out_pid, i_out_level, i_out_quantum};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch exp st=%0d pid=%0d lvl=%0d q=%0d,",
                                 $time, exp_r.status, exp_r.pid, exp_r.level,
                                 exp_r.quantum);
                        $display("    got st=%0d pid=%0d lvl=%0d q=%0d",
                                 got.status, got.pid, got.level, got.quantum);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.insert(expected_results.size(),
                                        schedule_step(t_func'(i_func), i_pid,
                                                      i_proc_class, i_req_level,
                                                      i_clear_age));
        end
    end
endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random scheduler commands through several register
// settings; mfs_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import mfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       start = 0;
    logic       busy;
    logic [1:0] i_func = 0;
    logic [3:0] i_pid = 0;
    logic [1:0] i_proc_class = 0;
    logic [1:0] i_req_level = 0;
    logic       i_clear_age = 0;
    logic       i_cfg_we = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [7:0] i_cfg_data = 0;
    logic       o_valid;
    logic [1:0] o_status;
    logic [3:0] o_out_pid;
    logic [1:0] o_out_level;
    logic [7:0] o_out_quantum;
    int         errors;
    int         pending;
    int         idle_cycles = 0;
    int         item_count = 0;
    int         tick_count = 0;
    logic [MAX_PROCS-1:0] admitted = '0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    multilevel_feedback_scheduler_unit DUT (.*);

    mfs_checker checker_inst (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_func, .i_pid,
        .i_proc_class, .i_req_level, .i_clear_age, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_valid(o_valid), .i_status(o_status), .i_out_pid(o_out_pid),
        .i_out_level(o_out_level), .i_out_quantum(o_out_quantum),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(t_func fn, logic [3:0] pid, logic [1:0] cls,
                            logic [1:0] lvl, logic clr);
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40));
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        i_func <= fn;
        i_pid <= pid;
        i_proc_class <= cls;
        i_req_level <= lvl;
        i_clear_age <= clr;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (fn == FN_ADMIT) admitted[pid] = 1;
        if (fn == FN_TICK) tick_count++;
        item_count++;
    endtask

    task automatic drain();
        start <= 0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] q0, logic [7:0] q1, logic [7:0] q2,
                              logic [7:0] t1, logic [7:0] t2);
        logic [7:0] vals [5];
        vals = '{q0, q1, q2, t1, t2};
        drain();
        for (int r = 0; r < 5; r++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= r[2:0];
            i_cfg_data <= vals[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    task automatic random_items(int n);
        int sel;
        logic [3:0] p;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            p = $urandom;
            if (sel < 28 || admitted == '0) begin
                send_cmd(FN_ADMIT, p, $urandom, $urandom, $urandom);
            end else if (sel < 55) begin
                while (!admitted[p]) p = p + 1;
                send_cmd(FN_REQUEUE, p, $urandom, $urandom, $urandom);
            end else if (sel < 82) begin
                send_cmd(FN_PICK, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_cmd(FN_TICK, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty pick, every class, level clamp, aging, full queue
        send_cmd(FN_PICK, 4'd0, 2'd0, 2'd0, 1'b0);
        send_cmd(FN_ADMIT, 4'd0, 2'd0, 2'd0, 1'b0);
        send_cmd(FN_ADMIT, 4'd15, 2'd1, 2'd0, 1'b0);
        send_cmd(FN_ADMIT, 4'd5, 2'd2, 2'd0, 1'b0);
        send_cmd(FN_ADMIT, 4'd10, 2'd3, 2'd3, 1'b1);
        send_cmd(FN_REQUEUE, 4'd15, 2'd3, 2'd3, 1'b0);
        send_cmd(FN_REQUEUE, 4'd5, 2'd0, 2'd1, 1'b1);
        send_cmd(FN_REQUEUE, 4'd0, 2'd0, 2'd2, 1'b0);
        for (int t = 0; t < 4; t++) send_cmd(FN_TICK, 4'd0, 2'd0, 2'd0, 1'b0);
        for (int t = 0; t < 5; t++) send_cmd(FN_PICK, 4'd0, 2'd0, 2'd0, 1'b0);
        for (int t = 0; t < 17; t++) send_cmd(FN_ADMIT, t[3:0], 2'd1, 2'd0, 1'b0);
        for (int t = 0; t < 17; t++) send_cmd(FN_PICK, 4'd0, 2'd0, 2'd0, 1'b0);

        random_items(150);
        write_regs(8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
        random_items(150);
        write_regs(8'd1, 8'd1, 8'd1, 8'd255, 8'd255);
        random_items(150);
        write_regs($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(0, 8), $urandom_range(0, 8));
        random_items(150);

        drain();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d items (%0d age ticks) over four register settings,", item_count,
                 tick_count);
        $display("including empty picks, full queues and zero and maximum thresholds.");
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
